FILE: hw/rtl/fpw_pkg.sv
// ----------------------------------------------------------------------------
// fpw_pkg
// Shared types, register indexes and colour packing for the pixel writer.
// ----------------------------------------------------------------------------
package fpw_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_PIXELS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LINES = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MODE  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_BASE = 3'd4;

	// reset values of the registers
	localparam logic [12:0] LINE_PIXELS_RST = 13'd1024;
	localparam logic [12:0] FRAME_LINES_RST = 13'd768;
	localparam logic [2:0]  PIXEL_BYTES_RST = 3'd1;

	// bytes-per-pixel code held as (count - 1)
	localparam logic [1:0] PB_ONE   = 2'd0;
	localparam logic [1:0] PB_TWO   = 2'd1;
	localparam logic [1:0] PB_THREE = 2'd2;
	localparam logic [1:0] PB_FOUR  = 2'd3;

	// one pixel ready for byte sequencing
	typedef struct packed {
		logic [31:0] addr;    // address of the first byte
		logic [31:0] data;    // bytes, least significant first
		logic [1:0]  last;    // byte count minus one
		logic        reject;  // pixel outside the frame
	} fpw_item_t;

	// pack an argb colour into 16 bits, rgb565 or argb1555
	function automatic logic [31:0] pack16(input logic [31:0] argb, input logic alpha);
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		a = argb[31:24];
		r = argb[23:16];
		g = argb[15:8];
		b = argb[7:0];
		if (alpha) begin
			pack16 = {16'd0, a[7], r[7:3], g[7:3], b[7:3]};
		end else begin
			pack16 = {16'd0, r[7:3], g[7:2], b[7:3]};
		end
	endfunction

endpackage

FILE: hw/rtl/fpw_front.sv
// ----------------------------------------------------------------------------
// fpw_front
// First pipeline stage: frame bounds check, line multiply and colour packing.
// ----------------------------------------------------------------------------
module fpw_front #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pixel_valid,
	output logic                    take_ready,
	input  logic [COORD_BITS-1:0]   column,
	input  logic [COORD_BITS-1:0]   row,
	input  logic [31:0]             pixel_color,
	input  logic [12:0]             line_pixels,
	input  logic [12:0]             frame_lines,
	input  logic [2:0]              pixel_bytes,
	input  logic                    alpha_mode,
	input  logic                    nxt_ready,
	output logic                    valid_s1,
	output logic [COORD_BITS-1:0]   col_s1,
	output logic [COORD_BITS+12:0]  prod_s1,
	output logic [31:0]             color_s1,
	output logic [1:0]              last_s1,
	output logic                    rej_s1
);

	localparam int unsigned PW = COORD_BITS + 13;

	logic          adv;
	logic          reject;
	logic [1:0]    last;
	logic [PW-1:0] prod;
	logic [31:0]   color;

	assign adv        = !valid_s1 || nxt_ready;
	assign take_ready = adv;

	// bounds check against the configured frame size
	assign reject = (PW'(column) >= PW'(line_pixels)) || (PW'(row) >= PW'(frame_lines));

	// pixel index of the line start
	assign prod = PW'(line_pixels) * PW'(row);

	// clamp the byte count to one..four
	always_comb begin
		case (pixel_bytes)
			3'd0, 3'd1: last = fpw_pkg::PB_ONE;
			3'd2:       last = fpw_pkg::PB_TWO;
			3'd3:       last = fpw_pkg::PB_THREE;
			default:    last = fpw_pkg::PB_FOUR;
		endcase
	end

	// only two-byte pixels are packed
	assign color = (last == fpw_pkg::PB_TWO) ? fpw_pkg::pack16(pixel_color, alpha_mode)
		: pixel_color;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pixel_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1   <= column;
			prod_s1  <= prod;
			color_s1 <= color;
			last_s1  <= last;
			rej_s1   <= reject;
		end
	end

endmodule

FILE: hw/rtl/fpw_addr.sv
// ----------------------------------------------------------------------------
// fpw_addr
// Second and third pipeline stages: byte offset, then buffer base add.
// ----------------------------------------------------------------------------
module fpw_addr #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s1,
	output logic                    take_ready,
	input  logic [COORD_BITS-1:0]   col_s1,
	input  logic [COORD_BITS+12:0]  prod_s1,
	input  logic [31:0]             color_s1,
	input  logic [1:0]              last_s1,
	input  logic                    rej_s1,
	input  logic [31:0]             buffer_base,
	input  logic                    nxt_ready,
	output logic                    valid_s3,
	output fpw_pkg::fpw_item_t      item_s3
);

	localparam int unsigned PW = COORD_BITS + 13;
	localparam int unsigned IW = PW + 1;
	localparam int unsigned OW = PW + 3;

	logic          adv2;
	logic          adv3;
	logic [IW-1:0] idx;
	logic [OW-1:0] offset;

	logic          valid_s2;
	logic [OW-1:0] off_s2;
	logic [31:0]   color_s2;
	logic [1:0]    last_s2;
	logic          rej_s2;

	assign adv3       = !valid_s3 || nxt_ready;
	assign adv2       = !valid_s2 || adv3;
	assign take_ready = adv2;

	// pixel index, then scale by bytes per pixel with shifts and one add
	assign idx = IW'(prod_s1) + IW'(col_s1);
	always_comb begin
		case (last_s1)
			fpw_pkg::PB_ONE:   offset = OW'(idx);
			fpw_pkg::PB_TWO:   offset = OW'(idx) << 1;
			fpw_pkg::PB_THREE: offset = OW'(idx) + (OW'(idx) << 1);
			default:           offset = OW'(idx) << 2;
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage two payload
	always_ff @(posedge clk) begin
		if (adv2) begin
			off_s2   <= offset;
			color_s2 <= color_s1;
			last_s2  <= last_s1;
			rej_s2   <= rej_s1;
		end
	end

	// stage three: base add, rejected pixels become a single zero byte
	always_ff @(posedge clk) begin
		if (adv3) begin
			item_s3.addr   <= rej_s2 ? 32'd0 : buffer_base + 32'(off_s2);
			item_s3.data   <= rej_s2 ? 32'd0 : color_s2;
			item_s3.last   <= rej_s2 ? fpw_pkg::PB_ONE : last_s2;
			item_s3.reject <= rej_s2;
		end
	end

endmodule

FILE: hw/rtl/fpw_emit.sv
// ----------------------------------------------------------------------------
// fpw_emit
// Byte sequencer: splits each pixel into byte writes behind an output register.
// ----------------------------------------------------------------------------
module fpw_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  fpw_pkg::fpw_item_t item,
	output logic               wr_valid,
	input  logic               wr_stall,
	output logic [31:0]        byte_address,
	output logic [7:0]         byte_data,
	output logic               final_byte,
	output logic               out_of_range
);

	logic        valid_q;
	logic [31:0] addr_q;
	logic [7:0]  data_q;
	logic        final_q;
	logic        oor_q;
	logic [1:0]  rem_q;
	logic [31:0] pend_addr_q;
	logic [23:0] pend_data_q;

	logic adv;
	logic take;
	logic step;

	// output register is free or its transfer completes this cycle
	assign adv        = !valid_q || !wr_stall;
	assign take       = adv && (rem_q == 2'd0);
	assign item_ready = take;
	assign step       = adv && (rem_q != 2'd0);

	// output valid and remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 2'd0;
		end else if (step) begin
			valid_q <= 1'b1;
			rem_q   <= rem_q - 2'd1;
		end else if (take) begin
			valid_q <= item_valid;
			rem_q   <= item_valid ? item.last : 2'd0;
		end
	end

	// byte payload and the bytes still to go
	always_ff @(posedge clk) begin
		if (step) begin
			addr_q      <= pend_addr_q;
			data_q      <= pend_data_q[7:0];
			final_q     <= (rem_q == 2'd1);
			oor_q       <= 1'b0;
			pend_addr_q <= pend_addr_q + 32'd1;
			pend_data_q <= pend_data_q >> 8;
		end else if (take) begin
			addr_q      <= item.addr;
			data_q      <= item.data[7:0];
			final_q     <= (item.last == fpw_pkg::PB_ONE);
			oor_q       <= item.reject;
			pend_addr_q <= item.addr + 32'd1;
			pend_data_q <= item.data[31:8];
		end
	end

	assign wr_valid     = valid_q;
	assign byte_address = addr_q;
	assign byte_data    = data_q;
	assign final_byte   = final_q;
	assign out_of_range = oor_q;

	// bytes pending only behind a valid output
	a_rem_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != 2'd0) |-> valid_q)
		else $error("bytes pending without a valid output");

	// the last byte of a pixel is flagged exactly when nothing remains
	a_final_matches_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (final_q == (rem_q == 2'd0)))
		else $error("final byte flag out of step with remaining count");

	// a rejected pixel is a single zero transfer
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && oor_q) |-> (final_q && addr_q == 32'd0 && data_q == 8'd0))
		else $error("rejected pixel transfer malformed");

	// each completed transfer of a multi-byte pixel moves to the next address
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !wr_stall && rem_q != 2'd0) |=> (addr_q == $past(addr_q) + 32'd1))
		else $error("byte address did not advance");

endmodule

FILE: hw/rtl/framebuffer_pixel_writer.sv
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer
// Turns pixel writes into little-endian byte writes into a frame buffer.
// ----------------------------------------------------------------------------
// Each pixel (column, row, argb colour) is checked against the frame size; an
// out-of-frame pixel gives one transfer with out_of_range and final_byte set
// and zero address and data. An in-frame pixel gives pixel_bytes transfers at
// buffer_base + (line_pixels*row + column)*pixel_bytes + j, lowest byte first,
// with two-byte pixels packed to rgb565 or, in alpha mode, argb1555. A pixel
// takes pixel_bytes byte transfers, clamped to one..four: the byte sequencer
// sends one byte a cycle while wr_stall is low, so one-byte pixels run at one
// a cycle. On its way to the first byte a pixel passes three pipeline stages
// and the output register.
// Configuration is taken at any time on the cfg channel but must only change
// while idle.
// ----------------------------------------------------------------------------
module framebuffer_pixel_writer #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data,
	// pixel channel
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [COORD_BITS-1:0]             column,
	input  logic [COORD_BITS-1:0]             row,
	input  logic [31:0]                       pixel_color,
	// byte write channel
	output logic                              wr_valid,
	input  logic                              wr_stall,
	output logic [31:0]                       byte_address,
	output logic [7:0]                        byte_data,
	output logic                              final_byte,
	output logic                              out_of_range
);

	logic [12:0] line_pixels_q;
	logic [12:0] frame_lines_q;
	logic [2:0]  pixel_bytes_q;
	logic        alpha_mode_q;
	logic [31:0] buffer_base_q;

	logic                   front_ready;
	logic                   valid_s1;
	logic [COORD_BITS-1:0]  col_s1;
	logic [COORD_BITS+12:0] prod_s1;
	logic [31:0]            color_s1;
	logic [1:0]             last_s1;
	logic                   rej_s1;
	logic                   addr_ready;
	logic                   valid_s3;
	fpw_pkg::fpw_item_t     item_s3;
	logic                   emit_ready;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pixels_q <= fpw_pkg::LINE_PIXELS_RST;
			frame_lines_q <= fpw_pkg::FRAME_LINES_RST;
			pixel_bytes_q <= fpw_pkg::PIXEL_BYTES_RST;
			alpha_mode_q  <= 1'b0;
			buffer_base_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpw_pkg::REG_LINE_PIXELS: line_pixels_q <= cfg_data[12:0];
				fpw_pkg::REG_FRAME_LINES: frame_lines_q <= cfg_data[12:0];
				fpw_pkg::REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[2:0];
				fpw_pkg::REG_ALPHA_MODE:  alpha_mode_q  <= cfg_data[0];
				fpw_pkg::REG_BUFFER_BASE: buffer_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pixel_stall = !front_ready;

	// bounds check, line multiply, colour packing
	fpw_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.take_ready  (front_ready),
		.column      (column),
		.row         (row),
		.pixel_color (pixel_color),
		.line_pixels (line_pixels_q),
		.frame_lines (frame_lines_q),
		.pixel_bytes (pixel_bytes_q),
		.alpha_mode  (alpha_mode_q),
		.nxt_ready   (addr_ready),
		.valid_s1    (valid_s1),
		.col_s1      (col_s1),
		.prod_s1     (prod_s1),
		.color_s1    (color_s1),
		.last_s1     (last_s1),
		.rej_s1      (rej_s1)
	);

	// byte offset and base address
	fpw_addr #(
		.COORD_BITS (COORD_BITS)
	) u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.take_ready  (addr_ready),
		.col_s1      (col_s1),
		.prod_s1     (prod_s1),
		.color_s1    (color_s1),
		.last_s1     (last_s1),
		.rej_s1      (rej_s1),
		.buffer_base (buffer_base_q),
		.nxt_ready   (emit_ready),
		.valid_s3    (valid_s3),
		.item_s3     (item_s3)
	);

	// byte sequencing and output register
	fpw_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s3),
		.item_ready   (emit_ready),
		.item         (item_s3),
		.wr_valid     (wr_valid),
		.wr_stall     (wr_stall),
		.byte_address (byte_address),
		.byte_data    (byte_data),
		.final_byte   (final_byte),
		.out_of_range (out_of_range)
	);

endmodule

FILE: sim/framebuffer_pixel_writer_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_check
// Watches the register, pixel and byte write channels of the pixel writer,
// works out the byte writes each accepted pixel must give and compares every
// byte transfer, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module framebuffer_pixel_writer_check #(
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fpw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            pixel_valid,
	input  logic                            pixel_stall,
	input  logic [COORD_BITS-1:0]           column,
	input  logic [COORD_BITS-1:0]           row,
	input  logic [31:0]                     pixel_color,
	input  logic                            wr_valid,
	input  logic                            wr_stall,
	input  logic [31:0]                     byte_address,
	input  logic [7:0]                      byte_data,
	input  logic                            final_byte,
	input  logic                            out_of_range,
	output int                              failures,
	output int                              pending,
	output int                              writes_checked
);
	import fpw_pkg::*;

	typedef struct packed {
		logic [31:0] address;
		logic [7:0]  data;
		logic        last;
		logic        reject;
	} byte_write_t;

	// own copy of the frame registers
	logic [12:0] frame_width;
	logic [12:0] frame_height;
	logic [2:0]  pixel_size;
	logic        alpha_packing;
	logic [31:0] base_address;

	byte_write_t byte_writes_due[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: byte write %s: got %h, expected %h", $time, what, got, want);
		failures++;
	endtask

	// byte writes that one pixel must give under the current registers
	function automatic void queue_byte_writes(input logic [COORD_BITS-1:0] col,
		input logic [COORD_BITS-1:0] line, input logic [31:0] argb);
		byte_write_t w;
		logic [31:0] colour;
		logic [63:0] offset;
		int count;
		int j;
		// outside the frame: one rejected transfer and nothing written
		if (col >= frame_width || line >= frame_height) begin
			w.address = '0;
			w.data = '0;
			w.last = 1'b1;
			w.reject = 1'b1;
			byte_writes_due.push_back(w);
			return;
		end
		// size below one counts as one, above four as four
		if (pixel_size == 3'd0) count = 1;
		else if (pixel_size > 3'd4) count = 4;
		else count = int'(pixel_size);
		// two-byte pixels are packed, all other sizes keep the low bytes
		colour = argb;
		if (count == 2) begin
			if (alpha_packing)
				colour = {16'd0, argb[31], argb[23:19], argb[15:11], argb[7:3]};
			else
				colour = {16'd0, argb[23:19], argb[15:10], argb[7:3]};
		end
		offset = 64'(frame_width);
		offset = offset * line + col;
		offset = offset * count;
		for (j = 0; j < count; j++) begin
			w.address = base_address + offset[31:0] + j;
			w.data = colour[8*j +: 8];
			w.last = (j == count - 1);
			w.reject = 1'b0;
			byte_writes_due.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		byte_write_t due;
		if (!arst_n) begin
			frame_width = LINE_PIXELS_RST;
			frame_height = FRAME_LINES_RST;
			pixel_size = PIXEL_BYTES_RST;
			alpha_packing = 1'b0;
			base_address = '0;
			byte_writes_due.delete();
			failures = 0;
			pending = 0;
			writes_checked = 0;
		end else begin
			// byte transfer against the oldest write still due
			if (wr_valid && !wr_stall) begin
				if (byte_writes_due.size() == 0) begin
					report_mismatch("with none due, address", byte_address, 32'd0);
				end else begin
					due = byte_writes_due.pop_front();
					if (byte_address !== due.address)
						report_mismatch("address", byte_address, due.address);
					if (byte_data !== due.data)
						report_mismatch("data", {24'd0, byte_data}, {24'd0, due.data});
					if (final_byte !== due.last)
						report_mismatch("final flag", {31'd0, final_byte}, {31'd0, due.last});
					if (out_of_range !== due.reject)
						report_mismatch("reject flag", {31'd0, out_of_range},
							{31'd0, due.reject});
				end
				writes_checked++;
			end
			// pixel transfer, predicted with the registers in force before this edge
			if (pixel_valid && !pixel_stall)
				queue_byte_writes(column, row, pixel_color);
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LINE_PIXELS: frame_width = cfg_data[12:0];
					REG_FRAME_LINES: frame_height = cfg_data[12:0];
					REG_PIXEL_BYTES: pixel_size = cfg_data[2:0];
					REG_ALPHA_MODE:  alpha_packing = cfg_data[0];
					REG_BUFFER_BASE: base_address = cfg_data;
					default: ;
				endcase
			end
			pending = byte_writes_due.size();
		end
	end

endmodule

FILE: sim/framebuffer_pixel_writer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_test
// Drives pixel writes through a series of frame settings, first hand-picked
// corner cases then random pixels with random idling on both channels, and
// leaves the checking to the channel checker beside the block.
// ----------------------------------------------------------------------------
module framebuffer_pixel_writer_test;
	import fpw_pkg::*;

	localparam int unsigned COORD_BITS = 12;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 16;
	localparam int RANDOM_PHASES = 10;
	localparam int PIXELS_PER_PHASE = 26;
	// index with no register behind it
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;
	logic                   pixel_valid;
	logic                   pixel_stall;
	logic [COORD_BITS-1:0]  column;
	logic [COORD_BITS-1:0]  row;
	logic [31:0]            pixel_color;
	logic                   wr_valid;
	logic                   wr_stall;
	logic [31:0]            byte_address;
	logic [7:0]             byte_data;
	logic                   final_byte;
	logic                   out_of_range;

	int failures;
	int pending;
	int writes_checked;
	int pixels_sent = 0;
	int register_writes = 0;
	int frame_settings = 0;
	int unsigned cycle_count = 0;
	bit calm = 1'b0;
	int cur_width = 1024;
	int cur_height = 768;

	framebuffer_pixel_writer #(.COORD_BITS(COORD_BITS)) dut (.*);

	framebuffer_pixel_writer_check #(.COORD_BITS(COORD_BITS)) check (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("run stopped at the cycle limit with %0d byte writes due", pending);
		$display("framebuffer_pixel_writer_test: errors");
		$finish;
	end

	function automatic int idle_cycles();
		if (calm)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// byte write receiver: random stall before each transfer
	initial begin : receiver
		int hold;
		wr_stall = 1'b0;
		forever begin
			hold = idle_cycles();
			if (hold > 0) begin
				wr_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			wr_stall <= 1'b0;
			@(posedge clk);
			while (!wr_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_pixel(input int col, input int line, input logic [31:0] argb);
		int gap;
		pixel_valid <= 1'b1;
		column <= col[COORD_BITS-1:0];
		row <= line[COORD_BITS-1:0];
		pixel_color <= argb;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		pixels_sent++;
		@(negedge clk);
		gap = idle_cycles();
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold the pixel channel until every byte write due has come out
	task automatic wait_drained();
		pixel_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
		input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		register_writes++;
		@(negedge clk);
	endtask

	// new frame setting, only once the block has gone idle
	task automatic setup_frame(input int width, input int height, input int size,
		input bit alpha, input logic [31:0] base, input bit spare);
		wait_drained();
		write_register(REG_LINE_PIXELS, width);
		write_register(REG_FRAME_LINES, height);
		write_register(REG_PIXEL_BYTES, size);
		write_register(REG_ALPHA_MODE, {31'd0, alpha});
		write_register(REG_BUFFER_BASE, base);
		if (spare)
			write_register(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		cur_width = width & 32'h1fff;
		cur_height = height & 32'h1fff;
		frame_settings++;
	endtask

	// frame extent with the register extremes now and then
	function automatic int pick_extent();
		case ($urandom_range(0, 9))
			0: return 1;
			1: return 4096;
			2: return 8191;
			3: return 0;
			4, 5: return $urandom_range(1, 16);
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	function automatic int pick_coord(input int extent);
		if (extent > COORD_MAX + 1)
			extent = COORD_MAX + 1;
		return $urandom_range(0, extent - 1);
	endfunction

	initial begin : stimulus
		int col;
		int line;
		logic [31:0] base;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixel_valid = 1'b0;
		column = '0;
		row = '0;
		pixel_color = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset frame: corners and the first pixel past each edge
		send_pixel(0, 0, 32'h0000_0000);
		send_pixel(1023, 767, 32'hffff_ffff);
		send_pixel(1024, 0, 32'h1234_5678);
		send_pixel(0, 768, 32'h8765_4321);
		send_pixel(COORD_MAX, COORD_MAX, 32'ha5a5_a5a5);

		// rgb565 with the address wrapping past the top
		setup_frame(4096, 4096, 2, 1'b0, 32'hffff_fff0, 1'b1);
		send_pixel(COORD_MAX, COORD_MAX, 32'hffff_ffff);
		send_pixel(1, 0, 32'h00f8_fc08);
		send_pixel(2, 0, 32'h7f07_0307);

		// argb1555
		setup_frame(4096, 4096, 2, 1'b1, 32'h0000_0000, 1'b0);
		send_pixel(0, 0, 32'h80ff_ffff);
		send_pixel(1, 1, 32'h7f08_0808);

		// tiny frame with three-byte pixels
		setup_frame(3, 2, 3, 1'b0, 32'h0000_1000, 1'b0);
		send_pixel(2, 1, 32'ha5c3_3c5a);
		send_pixel(3, 1, 32'h0102_0304);
		send_pixel(2, 2, 32'h0506_0708);

		// widest line register with four-byte pixels
		setup_frame(8191, 4096, 4, 1'b0, 32'hffff_ffff, 1'b0);
		send_pixel(COORD_MAX, COORD_MAX, $urandom);
		send_pixel(0, 0, 32'hdead_beef);

		// zero pixel size counts as one byte
		setup_frame(1, 1, 0, 1'b1, 32'h8000_0000, 1'b0);
		send_pixel(0, 0, 32'h1357_9bdf);
		send_pixel(1, 0, 32'h2468_ace0);

		// oversized pixel size saturates at four
		setup_frame(1, 1, 7, 1'b0, 32'h0000_00ff, 1'b0);
		send_pixel(0, 0, 32'hfedc_ba98);

		// zero width, then zero height, reject every pixel
		setup_frame(0, 4096, 4, 1'b0, 32'h0000_0000, 1'b0);
		send_pixel(0, 0, 32'h1111_1111);
		setup_frame(4096, 0, 1, 1'b0, 32'h0000_0000, 1'b0);
		send_pixel(0, 0, 32'h2222_2222);

		// random frame settings, mostly pixels inside the frame
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			calm = (phase % 4 == 3);
			if ($urandom_range(0, 1))
				base = $urandom;
			else
				base = 32'hffff_ff00 | $urandom_range(0, 255);
			setup_frame(pick_extent(), pick_extent(), $urandom_range(0, 7),
				$urandom_range(0, 1), base, $urandom_range(0, 3) == 0);
			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				if (cur_width == 0 || cur_height == 0 || $urandom_range(0, 4) == 0) begin
					col = $urandom_range(0, COORD_MAX);
					line = $urandom_range(0, COORD_MAX);
				end else begin
					col = pick_coord(cur_width);
					line = pick_coord(cur_height);
				end
				send_pixel(col, line, $urandom);
				// let the pipeline run dry mid-stream
				if (n == PIXELS_PER_PHASE / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
					wait_drained();
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d pixels over %0d frame settings, %0d register writes,",
			pixels_sent, frame_settings + 1, register_writes);
		$display("%0d byte transfers checked, %0d mismatches", writes_checked, failures);
		if (failures == 0) begin
			$display("framebuffer_pixel_writer_test: clean");
		end else begin
			$display("framebuffer_pixel_writer_test: errors");
		end
		$finish;
	end

endmodule
